// ===== rtl/core/vnoise_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnoise_pkg: shared types and constants for the value noise block
// Hash table (PERM), register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package vnoise_pkg;

    localparam int SEED_W = 8;
    localparam int FREQ_W = 24;
    localparam int OCT_W  = 5;
    localparam int COORD_W = 32;
    localparam int NOISE_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OCT  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_HASH1,
        S_HASH2,
        S_SQ,
        S_WT,
        S_BLX,
        S_BLY,
        S_ACC,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
    } t_coord;

    localparam logic [7:0] PERM [256] = '{
        8'd208,8'd34,8'd231,8'd213,8'd32,8'd248,8'd233,8'd56,8'd161,8'd78,8'd24,8'd140,
        8'd71,8'd48,8'd140,8'd254,8'd69,8'd255,8'd247,8'd247,8'd40,
        8'd185,8'd248,8'd251,8'd176,8'd28,8'd124,8'd204,8'd204,8'd76,8'd36,8'd1,8'd107,
        8'd28,8'd234,8'd163,8'd202,8'd224,8'd245,8'd128,8'd167,8'd204,
        8'd9,8'd92,8'd217,8'd54,8'd239,8'd174,8'd173,8'd102,8'd193,8'd189,8'd190,8'd121,
        8'd100,8'd108,8'd167,8'd44,8'd43,8'd77,8'd180,8'd204,8'd8,8'd81,
        8'd70,8'd223,8'd11,8'd38,8'd24,8'd254,8'd210,8'd210,8'd177,8'd32,8'd81,8'd195,
        8'd243,8'd125,8'd8,8'd169,8'd112,8'd32,8'd97,8'd53,8'd195,8'd13,
        8'd203,8'd9,8'd47,8'd104,8'd125,8'd117,8'd114,8'd124,8'd165,8'd203,8'd181,8'd235,
        8'd193,8'd206,8'd70,8'd180,8'd174,8'd0,8'd167,8'd181,8'd41,
        8'd164,8'd30,8'd116,8'd127,8'd198,8'd245,8'd146,8'd87,8'd224,8'd149,8'd206,8'd57,
        8'd4,8'd192,8'd210,8'd65,8'd210,8'd129,8'd240,8'd178,8'd105,
        8'd228,8'd108,8'd33,8'd148,8'd140,8'd40,8'd35,8'd195,8'd38,8'd58,8'd65,8'd207,
        8'd215,8'd253,8'd65,8'd85,8'd208,8'd76,8'd62,8'd3,8'd237,8'd55,8'd89,
        8'd232,8'd50,8'd217,8'd64,8'd244,8'd157,8'd199,8'd121,8'd252,8'd90,8'd17,8'd212,
        8'd203,8'd149,8'd152,8'd140,8'd187,8'd234,8'd177,8'd73,8'd174,
        8'd193,8'd100,8'd192,8'd143,8'd97,8'd53,8'd145,8'd135,8'd19,8'd103,8'd13,8'd90,
        8'd135,8'd151,8'd199,8'd91,8'd239,8'd247,8'd33,8'd39,8'd145,
        8'd101,8'd120,8'd99,8'd3,8'd186,8'd86,8'd99,8'd41,8'd237,8'd203,8'd111,8'd79,
        8'd220,8'd135,8'd158,8'd42,8'd30,8'd154,8'd120,8'd67,8'd87,8'd167,
        8'd135,8'd176,8'd183,8'd191,8'd253,8'd115,8'd184,8'd21,8'd233,8'd58,8'd129,8'd233,
        8'd142,8'd39,8'd128,8'd211,8'd118,8'd137,8'd139,8'd255,
        8'd114,8'd20,8'd218,8'd113,8'd154,8'd27,8'd127,8'd246,8'd250,8'd1,8'd8,8'd198,
        8'd250,8'd209,8'd92,8'd222,8'd173,8'd21,8'd88,8'd102,8'd219
    };

endpackage

// ===== rtl/core/vnoise_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnoise_if: valid/ready channel
// Generic handshake channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface vnoise_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/value_noise_2d_octaves.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_2d_octaves: fractal 2D value noise
// Octave sum of lattice value noise with smoothstep blending, Q0.16 result.
// ----------------------------------------------------------------------------
// The sample runs through D octaves (D is the configured octave count clamped
// to 1..MAX_OCTAVES). All products run through a single registered 33x33
// multiplier: after the coordinate scaling, per octave the sequencer steps
// through the coordinate window, two table hash steps, squares, weights, the
// two blends and the accumulation. The final normalization is a radix-2
// divider, one quotient bit per cycle over the 48-bit sum. Input is not
// ready while a sample is in work; the result waits in an output register
// until taken.
// ----------------------------------------------------------------------------
module value_noise_2d_octaves #(
    parameter int MAX_OCTAVES = 16,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    vnoise_if.sink   i_cfg,
    vnoise_if.sink   i_coord,
    vnoise_if.source o_noise
);
    import vnoise_pkg::*;

    localparam int DCNT_W = $clog2(MAX_OCTAVES + 1);
    localparam int ACC_W  = 24 + MAX_OCTAVES + 8;
    localparam int DEN_W  = MAX_OCTAVES + 17;
    localparam int SH_BIAS = COORD_FRAC_BITS + 16 - 32;

    // configuration
    logic [SEED_W-1:0] r_seed;
    logic [FREQ_W-1:0] r_freq;
    logic [OCT_W-1:0]  r_oct;
    t_cfg w_cfg;
    assign w_cfg = i_cfg.data;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_freq <= FREQ_W'(65536);
            r_oct  <= OCT_W'(1);
        end else if (i_cfg.valid) begin
            unique case (w_cfg.index)
                REG_SEED: r_seed <= w_cfg.data[SEED_W-1:0];
                REG_FREQ: r_freq <= w_cfg.data[FREQ_W-1:0];
                REG_OCT:  r_oct  <= w_cfg.data[OCT_W-1:0];
                default:  ;
            endcase
        end
    end

    // sequencer state
    t_state r_st, n_st;
    logic [3:0]  r_sub, n_sub;
    logic [COORD_W-1:0] r_cx, r_cy;
    logic [55:0] r_px, r_py;           // coord * freq
    logic [39:0] r_xw, r_yw;
    logic [7:0]  r_h0, r_h1;           // first-level hashes for y, y+1
    logic [7:0]  r_c [4];
    logic [31:0] r_s2x, r_s2y;
    logic [23:0] r_wx, r_wy;
    logic [33:0] r_lo, r_hi;
    logic [31:0] r_n;
    logic [ACC_W-1:0] r_acc;
    logic [DCNT_W-1:0] r_o, r_d;
    logic [NOISE_W-1:0] r_res;
    logic r_ovld;

    logic [32:0] w_ma, w_mb;
    logic [65:0] w_mp;
    logic w_dstart, w_ddone;
    logic [15:0] w_quo;

    vnoise_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_mp));

    vnoise_div #(.NUM_W(ACC_W), .DEN_W(DEN_W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(r_acc), .i_den({(DEN_W-16)'((64'd1 << r_d) - 64'd1), 16'd0}),
        .o_done(w_ddone), .o_quo(w_quo)
    );

    assign i_coord.ready = (r_st == S_IDLE) && !r_ovld;
    assign o_noise.valid = r_ovld;
    assign o_noise.data  = r_res;

    // window of the scaled coordinate for octave o: shift by o - SH_BIAS
    function automatic logic [39:0] win(input logic [55:0] p, input int sh);
        logic [119:0] e;
        e = {64'd0, p};
        if (sh >= 0) e = e << sh;
        else         e = e >> (-sh);
        return e[39:0];
    endfunction

    function automatic logic [31:0] tval(input logic [31:0] s);
        return 32'(33'h0C000_0000 - {2'b0, s[31:1]});
    endfunction

    logic [7:0] w_xi, w_yi;
    assign w_xi = r_xw[39:32];
    assign w_yi = r_yw[39:32];

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_st)
            S_SCALE: begin
                w_ma = {1'b0, (r_sub == 4'd0) ? r_cx : r_cy};
                w_mb = 33'(r_freq);
            end
            S_SQ: begin
                w_ma = {1'b0, (r_sub == 4'd0) ? r_xw[31:0] : r_yw[31:0]};
                w_mb = w_ma;
            end
            S_WT: begin
                w_ma = {1'b0, (r_sub == 4'd0) ? r_s2x : r_s2y};
                w_mb = {1'b0, tval((r_sub == 4'd0) ? r_xw[31:0] : r_yw[31:0])};
            end
            S_BLX: begin
                // a*(2^24-w) + b*w = a*2^24 + (b-a)*w, signed diff offset by 256
                w_ma = 33'({1'b0, (r_sub == 4'd0) ? r_c[1] : r_c[3]} + 9'd256
                           - {1'b0, (r_sub == 4'd0) ? r_c[0] : r_c[2]});
                w_mb = 33'(r_wx);
            end
            S_BLY: begin
                // hi - lo offset by 2^32 to stay positive
                w_ma = 33'(r_hi + 34'h1_0000_0000 - r_lo);
                w_mb = 33'(r_wy);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_st = r_st;
        n_sub = r_sub + 4'd1;
        w_dstart = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                n_sub = '0;
                if (i_coord.valid && i_coord.ready) n_st = S_SCALE;
            end
            S_SCALE: if (r_sub == 4'd2) begin n_st = S_HASH1; n_sub = '0; end
            S_HASH1: begin n_st = S_HASH2; n_sub = '0; end
            S_HASH2: begin n_st = S_SQ; n_sub = '0; end
            S_SQ:  if (r_sub == 4'd2) begin n_st = S_WT; n_sub = '0; end
            S_WT:  if (r_sub == 4'd2) begin n_st = S_BLX; n_sub = '0; end
            S_BLX: if (r_sub == 4'd2) begin n_st = S_BLY; n_sub = '0; end
            S_BLY: if (r_sub == 4'd1) begin n_st = S_ACC; n_sub = '0; end
            S_ACC: begin
                n_sub = '0;
                if (r_o == r_d - 1'b1) n_st = S_DIV;
                else n_st = S_HASH1;
            end
            S_DIV: begin
                // start once the last octave is in the sum
                n_sub = 4'd1;
                if (r_sub == 4'd0) w_dstart = 1'b1;
                if (w_ddone) n_st = S_OUT;
            end
            S_OUT: if (!r_ovld) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    logic [33:0] w_bl;
    logic [57:0] w_by;
    always_comb begin
        // (b-a+256)*w - 256*w + a*2^24, Q8.24 stays under 2^32
        w_bl = 34'({r_c[0], 24'd0} + w_mp[33:0] - {2'b0, r_wx, 8'd0});
        w_by = {r_lo, 24'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_sub  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_sub <= n_sub;
            if (o_noise.valid && o_noise.ready) r_ovld <= 1'b0;
            if (r_st == S_DIV && w_ddone) begin
                r_ovld <= 1'b1;
                r_res  <= w_quo;
            end
        end
        unique case (r_st)
            S_IDLE: begin
                r_cx  <= i_coord.data.coord_x;
                r_cy  <= i_coord.data.coord_y;
                r_acc <= '0;
                r_o   <= '0;
                if (r_oct == '0) r_d <= DCNT_W'(1);
                else if (32'(r_oct) > MAX_OCTAVES) r_d <= DCNT_W'(MAX_OCTAVES);
                else r_d <= DCNT_W'(r_oct);
            end
            S_SCALE: begin
                if (r_sub == 4'd1) r_px <= w_mp[55:0];
                if (r_sub == 4'd2) r_py <= w_mp[55:0];
            end
            S_HASH1: begin
                r_xw <= win(r_px, 32'(r_o) - SH_BIAS);
                r_yw <= win(r_py, 32'(r_o) - SH_BIAS);
            end
            S_HASH2: begin
                r_h0 <= PERM[8'(w_yi + r_seed)];
                r_h1 <= PERM[8'(w_yi + 8'd1 + r_seed)];
            end
            S_SQ: begin
                if (r_sub == 4'd0) begin
                    r_c[0] <= PERM[8'(r_h0 + w_xi + r_seed)];
                    r_c[1] <= PERM[8'(r_h0 + w_xi + 8'd1 + r_seed)];
                    r_c[2] <= PERM[8'(r_h1 + w_xi + r_seed)];
                    r_c[3] <= PERM[8'(r_h1 + w_xi + 8'd1 + r_seed)];
                end
                if (r_sub == 4'd1) r_s2x <= w_mp[63:32];
                if (r_sub == 4'd2) r_s2y <= w_mp[63:32];
            end
            S_WT: begin
                if (r_sub == 4'd1) r_wx <= w_mp[61:38];
                if (r_sub == 4'd2) r_wy <= w_mp[61:38];
            end
            S_BLX: begin
                if (r_sub == 4'd1) r_lo <= w_bl;
                if (r_sub == 4'd2) r_hi <= 34'({r_c[2], 24'd0} + w_mp[33:0]
                                              - {2'b0, r_wx, 8'd0});
            end
            S_BLY: begin
                // lo*2^24 + (hi-lo+2^32)*w - 2^32*w
                if (r_sub == 4'd1)
                    r_n <= 32'((w_by + w_mp[57:0] - {r_wy, 32'd0}) >> 24);
            end
            S_ACC: begin
                r_acc <= r_acc + (ACC_W'(r_n) << (r_d - 1'b1 - r_o));
                r_o   <= r_o + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/vnoise_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnoise_mul: shared multiplier
// One registered 33x33 unsigned multiply, reused by the scaling, square, weight and blend steps.
// ----------------------------------------------------------------------------
module vnoise_mul (
    input  logic        i_clk,
    input  logic [32:0] i_a,
    input  logic [32:0] i_b,
    output logic [65:0] o_p
);
    logic [65:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule

// ===== rtl/core/vnoise_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnoise_div: restoring divider
// Radix-2 unsigned divide, one quotient bit per cycle; low 16 bits kept.
// ----------------------------------------------------------------------------
module vnoise_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 34
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [15:0]      o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   w_trial;

    always_comb begin
        w_trial = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        n_q = {r_q[NUM_W-2:0], 1'b0};
        n_rem = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q[15:0];
endmodule
